// ----- hw/rtl/pcbd_pkg.sv -----
// Package for the prefix code bit decoder: transaction structs, table entry layout
// and action codes. No dependencies; imported by the decoder and compare units.
package pcbd_pkg;

    localparam int SYM_W   = 8;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 32;
    localparam int INDEX_W = 8;
    localparam int CFG_W   = 9;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_DECODE = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [INDEX_W-1:0] entry_index;
        logic [SYM_W-1:0]   entry_symbol;
        logic [LEN_W-1:0]   entry_length;
        logic [CODE_W-1:0]  entry_code;
        logic               code_bit;
    } pcbd_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             overflow_error;
    } pcbd_result_t;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } pcbd_entry_t;

    localparam int ENTRY_W = $bits(pcbd_entry_t);

endpackage

// ----- hw/rtl/prefix_code_bit_decoder_unit.sv -----
// Prefix code bit decoder. Load and start transactions leave the input free. A decode
// transaction scans entries 0 .. min(entries_in_use, TABLE_DEPTH)-1, one per cycle
// on the single read port of the table RAM. The input stalls until the scan ends
// without a match or finds one, then, when there is a result, until the output
// register is free to take it.
// Reset clears the accumulator, entries_in_use and the output; the table is undefined.
module prefix_code_bit_decoder_unit
    import pcbd_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pcbd_item_t       item,
    output logic             result_valid,
    input  logic             result_stall,
    output pcbd_result_t     result,
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(MAX_CODE_LEN + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [MAX_CODE_LEN-1:0] pending_bits_reg, pending_bits_next;
    logic [MAX_CODE_LEN-1:0] pending_mask_reg, pending_mask_next;
    logic [CW-1:0]           pending_count_reg, pending_count_next;
    logic [CFG_W-1:0]        entries_reg, entries_next;
    logic [NW-1:0]           limit_reg, limit_next;
    logic [NW-1:0]           issue_cnt_reg, issue_cnt_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    pcbd_result_t            res_reg, res_next;
    logic                    result_valid_reg, result_valid_next;
    pcbd_result_t            result_reg, result_next;

    logic        accept;
    logic        ram_wr_en;
    logic        ram_rd_en;
    pcbd_entry_t wr_entry;
    pcbd_entry_t rd_entry;
    logic        hit;
    logic        out_free;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign out_free   = !result_valid_reg || !result_stall;

    // Table write: drop loads that land beyond the table.
    assign ram_wr_en = accept && (item.action == ACT_LOAD)
                       && ({1'b0, item.entry_index} < CFG_W'(TABLE_DEPTH));
    assign wr_entry.symbol = item.entry_symbol;
    assign wr_entry.length = item.entry_length;
    assign wr_entry.code   = item.entry_code;

    // Scan reads one entry per cycle; the compare sees it in the cycle after.
    assign ram_rd_en = (state_reg == ST_SCAN) && (issue_cnt_reg < limit_reg);

    pcbd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (item.entry_index[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_cnt_reg[AW-1:0]),
        .rd_data (rd_entry)
    );

    pcbd_match #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_match (
        .entry         (rd_entry),
        .pending_bits  (pending_bits_reg),
        .pending_mask  (pending_mask_reg),
        .pending_count (pending_count_reg),
        .hit           (hit)
    );

    always_comb
    begin
        state_next         = state_reg;
        pending_bits_next  = pending_bits_reg;
        pending_mask_next  = pending_mask_reg;
        pending_count_next = pending_count_reg;
        entries_next       = entries_reg;
        limit_next         = limit_reg;
        issue_cnt_next     = issue_cnt_reg;
        cmp_vld_next       = 1'b0;
        res_next           = res_reg;
        result_valid_next  = result_valid_reg;
        result_next        = result_reg;

        if (cfg_write_en)
        begin
            entries_next = cfg_write_data;
        end

        // Drop the output once the sink takes it.
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        ACT_START:
                        begin
                            pending_bits_next  = '0;
                            pending_mask_next  = '0;
                            pending_count_next = '0;
                        end
                        ACT_DECODE:
                        begin
                            // Shift the bit in; the count saturates at the longest code.
                            pending_bits_next = {pending_bits_reg[MAX_CODE_LEN-2:0],
                                                 item.code_bit};
                            pending_mask_next = {pending_mask_reg[MAX_CODE_LEN-2:0], 1'b1};
                            if (pending_count_reg < CW'(MAX_CODE_LEN))
                            begin
                                pending_count_next = pending_count_reg + CW'(1);
                            end
                            if (entries_reg > CFG_W'(TABLE_DEPTH))
                            begin
                                limit_next = NW'(TABLE_DEPTH);
                            end
                            else
                            begin
                                limit_next = entries_reg[NW-1:0];
                            end
                            issue_cnt_next = '0;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            // Load goes straight to the RAM; unused code is ignored.
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (ram_rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + NW'(1);
                end
                if (cmp_vld_reg && hit)
                begin
                    // First match in index order wins.
                    res_next.symbol         = rd_entry.symbol;
                    res_next.overflow_error = 1'b0;
                    pending_bits_next       = '0;
                    pending_mask_next       = '0;
                    pending_count_next      = '0;
                    state_next              = ST_EMIT;
                end
                else if (issue_cnt_reg == limit_reg)
                begin
                    // Every entry checked without a match.
                    if (pending_count_reg == CW'(MAX_CODE_LEN))
                    begin
                        res_next.symbol         = '0;
                        res_next.overflow_error = 1'b1;
                        pending_bits_next       = '0;
                        pending_mask_next       = '0;
                        pending_count_next      = '0;
                        state_next              = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmp_vld_next = ram_rd_en;
                end
            end

            ST_EMIT:
            begin
                // Hold until the output register frees up.
                if (out_free)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pending_bits_reg  <= '0;
            pending_mask_reg  <= '0;
            pending_count_reg <= '0;
            entries_reg       <= '0;
            limit_reg         <= '0;
            issue_cnt_reg     <= '0;
            cmp_vld_reg       <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pending_bits_reg  <= pending_bits_next;
            pending_mask_reg  <= pending_mask_next;
            pending_count_reg <= pending_count_next;
            entries_reg       <= entries_next;
            limit_reg         <= limit_next;
            issue_cnt_reg     <= issue_cnt_next;
            cmp_vld_reg       <= cmp_vld_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg <= CW'(MAX_CODE_LEN))
        else $error("accumulated bit count exceeds the longest code");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= limit_reg))
        else $error("scan read past the entries in use");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == ST_SCAN))
        else $error("compare pending outside a scan");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.overflow_error) |-> (result_reg.symbol == '0))
        else $error("overflow result carries a nonzero symbol");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside the emit step");

endmodule

// ----- hw/rtl/pcbd_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No package dependency.
module pcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/pcbd_match.sv -----
// Compare unit: checks one table entry against the accumulated code bits.
// Depends on pcbd_pkg for the entry layout.
module pcbd_match
    import pcbd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
) (
    input  pcbd_entry_t                           entry,
    input  logic [MAX_CODE_LEN-1:0]               pending_bits,
    input  logic [MAX_CODE_LEN-1:0]               pending_mask,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]     pending_count,
    output logic                                  hit
);

    logic len_ok;
    logic bits_ok;

    // Length must be nonzero and equal to the accumulated count; mask keeps the
    // low count bits, so code bits above the length drop out.
    assign len_ok  = (entry.length != '0) && (entry.length == LEN_W'(pending_count));
    assign bits_ok = ((entry.code[MAX_CODE_LEN-1:0] ^ pending_bits) & pending_mask) == '0;
    assign hit     = len_ok && bits_ok;

endmodule
